>>> hw/rtl/vntg_pkg.sv
// ----------------------------------------------------------------------------
// vntg_pkg: shared types and constants of the value noise tile generator
// Payload structs, register indexes, hash and reciprocal constants, and
// queue depths.
// ----------------------------------------------------------------------------
package vntg_pkg;

  localparam int COORD_BITS = 12;

  localparam int MID_DEPTH = 8;
  localparam int MID_AW    = $clog2(MID_DEPTH);
  localparam int OUT_DEPTH = 16;
  localparam int OUT_AW    = $clog2(OUT_DEPTH);

  localparam logic [31:0] HASH_MUL_X   = 32'd374761393;
  localparam logic [31:0] HASH_MUL_Y   = 32'd668265263;
  localparam logic [31:0] HASH_MUL_OUT = 32'd1274126177;
  localparam int          HASH_SHIFT   = 13;

  localparam logic [16:0] ONE_Q16   = 17'd65536;
  localparam logic [17:0] THREE_Q16 = 18'd196608;

  // terrain moduli and ceiling reciprocals (exact for the sum widths used)
  localparam int          MOD_BLOCK   = 13;
  localparam int          MOD_DIRT    = 5;
  localparam logic [16:0] RCP_BLOCK   = 17'd80660;
  localparam int          RCP_BLOCK_SH = 20;
  localparam logic [21:0] RCP_DIRT    = 22'd3355444;
  localparam int          RCP_DIRT_SH = 24;

  localparam logic [1:0] KIND_GRASS   = 2'd0;
  localparam logic [1:0] KIND_DIRT    = 2'd1;
  localparam logic [1:0] KIND_BLOCKED = 2'd2;

  localparam logic [1:0] REG_SEED  = 2'd0;
  localparam logic [1:0] REG_SCALE = 2'd1;
  localparam logic [1:0] REG_MIN   = 2'd2;
  localparam logic [1:0] REG_MAX   = 2'd3;

  typedef struct packed {
    logic [COORD_BITS-1:0] tile_x;
    logic [COORD_BITS-1:0] tile_y;
  } tile_t;

  typedef struct packed {
    logic signed [7:0] tile_height;
    logic [1:0]        tile_kind;
  } result_t;

  typedef struct packed {
    logic [31:0]       seed;
    logic [15:0]       scale;
    logic signed [7:0] min_h;
    logic signed [7:0] max_h;
  } cfg_t;

  // request from front to back: lattice cell, fractions, terrain kind
  typedef struct packed {
    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cy;
    logic [15:0]           fx;
    logic [15:0]           fy;
    logic [1:0]            kind;
  } cell_req_t;

  // queue status seen by the back end
  typedef struct packed {
    logic      empty;
    cell_req_t head;
  } cellq_stat_t;

endpackage

>>> hw/rtl/value_noise_tile_generator.sv
// ----------------------------------------------------------------------------
// value_noise_tile_generator: 2-D value noise tile height and terrain kind
// Top level: APB register file, front end, cell queue and back end.
// ----------------------------------------------------------------------------
// Push one tile coordinate per cycle while full is low; one result (height,
// kind) comes out per request, in order, through a queue-style result port.
// Throughput is one request per clock as long as results are popped; a
// result passes 3 front stages, the cell queue write, 7 back stages and the
// result FIFO write before it shows on the port. Backpressure on the result
// side first holds up to 16 requests in the back stages and result FIFO, then
// 8 more in the front stages and cell queue, after which full rises.
// Registers: 0 seed (0x0), 1 scale Q0.16 (0x4), 2 min height (0x8),
// 3 max height (0xC); write them only while no request is in flight.
module value_noise_tile_generator import vntg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // request side
  input  tile_t       tile,
  input  logic        push,
  output logic        full,
  // result side
  output result_t     result,
  output logic        empty,
  input  logic        pop,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t cfg;

  assign pready = 1'b1;

  // register writes on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.seed  <= 32'd0;
      cfg.scale <= 16'd7864;
      cfg.min_h <= 8'sd0;
      cfg.max_h <= 8'sd7;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_SEED:  cfg.seed  <= pwdata;
        REG_SCALE: cfg.scale <= pwdata[15:0];
        REG_MIN:   cfg.min_h <= pwdata[7:0];
        REG_MAX:   cfg.max_h <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // readback, heights sign-extended
  always_comb begin
    case (paddr[3:2])
      REG_SEED:  prdata = cfg.seed;
      REG_SCALE: prdata = {16'd0, cfg.scale};
      REG_MIN:   prdata = {{24{cfg.min_h[7]}}, cfg.min_h};
      REG_MAX:   prdata = {{24{cfg.max_h[7]}}, cfg.max_h};
      default:   prdata = '0;
    endcase
  end

  logic        q_push, q_pop;
  cell_req_t   q_data;
  cellq_stat_t q_stat;

  // front: scaling and terrain classification
  vntg_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .tile   (tile),
    .push   (push),
    .full   (full),
    .q_push (q_push),
    .q_data (q_data),
    .q_pop  (q_pop)
  );

  vntg_cellq u_cellq (
    .clk    (clk),
    .rst    (rst),
    .q_push (q_push),
    .q_data (q_data),
    .q_pop  (q_pop),
    .stat   (q_stat)
  );

  // back: hashing, blend, map and result FIFO
  vntg_back u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .stat   (q_stat),
    .q_pop  (q_pop),
    .result (result),
    .empty  (empty),
    .pop    (pop)
  );

  // back end only takes from a queue that holds a request
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty)
    else $error("cell queue popped while empty");

  // full can only rise right after a request was taken
  a_full_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(full) |-> $past(push && !full))
    else $error("full rose without an accepted request");

  // a pushed request reaches the cell queue through front stages a, b and c
  a_front_latency: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |-> ##3 q_push)
    else $error("front end lost a request");

endmodule

>>> hw/rtl/vntg_front.sv
// ----------------------------------------------------------------------------
// vntg_front: input stage
// Accepts coordinates, scales them into cell and fraction, classifies the
// terrain kind, and pushes one request per tile into the cell queue.
// ----------------------------------------------------------------------------
module vntg_front import vntg_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  tile_t     tile,
  input  logic      push,
  output logic      full,
  output logic      q_push,
  output cell_req_t q_data,
  input  logic      q_pop
);

  localparam int CB = COORD_BITS;

  // requests accepted but not yet taken from the cell queue
  logic [MID_AW:0] used;
  logic            accept;

  assign full   = (used == (MID_AW+1)'(MID_DEPTH));
  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else begin
      used <= used + (MID_AW+1)'(accept) - (MID_AW+1)'(q_pop);
    end
  end

  // stage a: captured coordinate
  logic          a_vld;
  tile_t         a_tile;
  // stage b: scaled products and kind sums
  logic          b_vld;
  logic [CB+15:0] b_px, b_py;
  logic [CB:0]   b_s13;
  logic [CB+3:0] b_s5;
  // stage c: quotients
  logic          c_vld;
  logic [CB+15:0] c_px, c_py;
  logic [CB:0]   c_s13, c_q13;
  logic [CB+3:0] c_s5, c_q5;

  logic [CB+17:0] prod13;
  logic [CB+25:0] prod5;

  assign prod13 = (CB+18)'(b_s13) * (CB+18)'(RCP_BLOCK);
  assign prod5  = (CB+26)'(b_s5) * (CB+26)'(RCP_DIRT);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      c_vld <= 1'b0;
    end else begin
      a_vld <= accept;
      b_vld <= a_vld;
      c_vld <= b_vld;
    end
    a_tile <= tile;
    b_px   <= (CB+16)'(a_tile.tile_x) * (CB+16)'(cfg.scale);
    b_py   <= (CB+16)'(a_tile.tile_y) * (CB+16)'(cfg.scale);
    b_s13  <= (CB+1)'(a_tile.tile_x) + (CB+1)'(a_tile.tile_y);
    b_s5   <= (CB+4)'(a_tile.tile_x) * (CB+4)'(3) + (CB+4)'(a_tile.tile_y) * (CB+4)'(7);
    c_px   <= b_px;
    c_py   <= b_py;
    c_s13  <= b_s13;
    c_s5   <= b_s5;
    c_q13  <= (CB+1)'(prod13 >> RCP_BLOCK_SH);
    c_q5   <= (CB+4)'(prod5 >> RCP_DIRT_SH);
  end

  logic blocked, dirt;
  assign blocked = (c_s13 == (CB+1)'(c_q13 * (CB+1)'(MOD_BLOCK)));
  assign dirt    = (c_s5 == (CB+4)'(c_q5 * (CB+4)'(MOD_DIRT)));

  always_comb begin
    q_data.cx = c_px[CB+15:16];
    q_data.cy = c_py[CB+15:16];
    q_data.fx = c_px[15:0];
    q_data.fy = c_py[15:0];
    if (blocked) begin
      q_data.kind = KIND_BLOCKED;
    end else if (dirt) begin
      q_data.kind = KIND_DIRT;
    end else begin
      q_data.kind = KIND_GRASS;
    end
  end

  assign q_push = c_vld;

endmodule

>>> hw/rtl/vntg_cellq.sv
// ----------------------------------------------------------------------------
// vntg_cellq: cell request queue
// Short FIFO between front and back ends; the front never pushes when full.
// ----------------------------------------------------------------------------
module vntg_cellq import vntg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_push,
  input  cell_req_t   q_data,
  input  logic        q_pop,
  output cellq_stat_t stat
);

  cell_req_t       mem [MID_DEPTH];
  logic [MID_AW-1:0] wr_ptr, rd_ptr;
  logic [MID_AW:0]   count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (q_push) wr_ptr <= wr_ptr + 1'b1;
      if (q_pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (MID_AW+1)'(q_push) - (MID_AW+1)'(q_pop);
    end
    if (q_push) mem[wr_ptr] <= q_data;
  end

  assign stat.empty = (count == '0);
  assign stat.head  = mem[rd_ptr];

endmodule

>>> hw/rtl/vntg_back.sv
// ----------------------------------------------------------------------------
// vntg_back: hash, blend and map pipeline
// Seven-stage pipeline: corner hashes, smoothstep weights, bilinear blend,
// height mapping and clamp, then a result FIFO.
// ----------------------------------------------------------------------------
module vntg_back import vntg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  cellq_stat_t stat,
  output logic        q_pop,
  output result_t     result,
  output logic        empty,
  input  logic        pop
);

  localparam int CB = COORD_BITS;

  function automatic logic [31:0] xs(input logic [31:0] h);
    return (h << HASH_SHIFT) ^ h;
  endfunction

  function automatic logic [23:0] blend(input logic [23:0] a, input logic [23:0] b,
                                        input logic [16:0] w);
    logic [41:0] s;
    s = 42'(a) * 42'(ONE_Q16 - w) + 42'(b) * 42'(w);
    return s[39:16];
  endfunction

  // credit: requests issued and results not yet popped
  logic [OUT_AW:0] out_used;
  logic            out_pop;
  logic            issue;

  assign out_pop = pop && !empty;
  assign issue   = !stat.empty && (out_used != (OUT_AW+1)'(OUT_DEPTH));
  assign q_pop   = issue;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_used <= '0;
    end else begin
      out_used <= out_used + (OUT_AW+1)'(issue) - (OUT_AW+1)'(out_pop);
    end
  end

  logic [7:1] vld;
  logic [1:0] kind [7:1];

  // stage 1
  logic [CB-1:0] s1_cx, s1_cy;
  logic [15:0]   s1_fx, s1_fy;
  // stage 2
  logic [31:0]   s2_hx0, s2_hx1;
  logic [CB-1:0] s2_cy;
  logic [15:0]   s2_fx, s2_fy, s2_f2x, s2_f2y;
  // stage 3
  logic [31:0]   s3_g00, s3_g10, s3_g01, s3_g11;
  logic [16:0]   s3_wx, s3_wy;
  // stage 4
  logic [23:0]   s4_v00, s4_v10, s4_v01, s4_v11;
  logic [16:0]   s4_wx, s4_wy;
  // stage 5
  logic [23:0]   s5_t0, s5_t1;
  logic [16:0]   s5_wy;
  // stage 6
  logic [23:0]   s6_sample;
  // stage 7
  logic [8:0]    s7_q;
  logic          s7_neg;

  logic [31:0] mx0, mx1, my0, my1, a0, a1;
  logic [31:0] fxx, fyy;
  logic [33:0] wxp, wyp;
  logic signed [9:0] rng;
  logic [8:0]  mag;
  logic [32:0] hprod;

  assign mx0 = 32'(s1_cx) * HASH_MUL_X;
  assign mx1 = 32'((CB+1)'(s1_cx) + (CB+1)'(1)) * HASH_MUL_X;
  assign fxx = 32'(s1_fx) * 32'(s1_fx);
  assign fyy = 32'(s1_fy) * 32'(s1_fy);

  assign a0  = xs(s2_hx0);
  assign a1  = xs(s2_hx1);
  assign my0 = 32'(s2_cy) * HASH_MUL_Y;
  assign my1 = 32'((CB+1)'(s2_cy) + (CB+1)'(1)) * HASH_MUL_Y;
  assign wxp = 34'(s2_f2x) * 34'(THREE_Q16 - {1'b0, s2_fx, 1'b0});
  assign wyp = 34'(s2_f2y) * 34'(THREE_Q16 - {1'b0, s2_fy, 1'b0});

  assign rng   = {{2{cfg.max_h[7]}}, cfg.max_h} - {{2{cfg.min_h[7]}}, cfg.min_h} + 10'sd1;
  assign mag   = rng[9] ? 9'(-rng) : rng[8:0];
  assign hprod = 33'(s6_sample) * 33'(mag);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[6:1], issue};
    end
    kind[1] <= stat.head.kind;
    for (int i = 2; i <= 7; i++) kind[i] <= kind[i-1];

    s1_cx <= stat.head.cx;
    s1_cy <= stat.head.cy;
    s1_fx <= stat.head.fx;
    s1_fy <= stat.head.fy;

    s2_hx0 <= cfg.seed ^ mx0;
    s2_hx1 <= cfg.seed ^ mx1;
    s2_cy  <= s1_cy;
    s2_fx  <= s1_fx;
    s2_fy  <= s1_fy;
    s2_f2x <= fxx[31:16];
    s2_f2y <= fyy[31:16];

    s3_g00 <= xs(a0 ^ my0);
    s3_g10 <= xs(a1 ^ my0);
    s3_g01 <= xs(a0 ^ my1);
    s3_g11 <= xs(a1 ^ my1);
    s3_wx  <= wxp[32:16];
    s3_wy  <= wyp[32:16];

    // only the low 24 bits of the final hash product are kept
    s4_v00 <= s3_g00[23:0] * HASH_MUL_OUT[23:0];
    s4_v10 <= s3_g10[23:0] * HASH_MUL_OUT[23:0];
    s4_v01 <= s3_g01[23:0] * HASH_MUL_OUT[23:0];
    s4_v11 <= s3_g11[23:0] * HASH_MUL_OUT[23:0];
    s4_wx  <= s3_wx;
    s4_wy  <= s3_wy;

    s5_t0 <= blend(s4_v00, s4_v10, s4_wx);
    s5_t1 <= blend(s4_v01, s4_v11, s4_wx);
    s5_wy <= s4_wy;

    s6_sample <= blend(s5_t0, s5_t1, s5_wy);

    s7_q   <= hprod[32:24];
    s7_neg <= rng[9];
  end

  logic signed [10:0] hmin, hmax, hraw;
  logic signed [7:0]  height;

  assign hmin = {{3{cfg.min_h[7]}}, cfg.min_h};
  assign hmax = {{3{cfg.max_h[7]}}, cfg.max_h};
  assign hraw = s7_neg ? hmin - $signed({2'b00, s7_q}) : hmin + $signed({2'b00, s7_q});
  assign height = (hraw > hmax) ? cfg.max_h : hraw[7:0];

  // result FIFO; credit keeps it from overflowing
  result_t           mem [OUT_DEPTH];
  logic [OUT_AW-1:0] wr_ptr, rd_ptr;
  logic [OUT_AW:0]   count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (vld[7]) wr_ptr <= wr_ptr + 1'b1;
      if (out_pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (OUT_AW+1)'(vld[7]) - (OUT_AW+1)'(out_pop);
    end
    if (vld[7]) mem[wr_ptr] <= '{tile_height: height, tile_kind: kind[7]};
  end

  assign result = mem[rd_ptr];
  assign empty  = (count == '0);

endmodule

>>> verif/tb_value_noise_tile_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_value_noise_tile_generator: self-checking bench for the noise tile block
// Drives tile coordinates through the push/full port and pops results with
// random gaps. A local predictor computes the expected height and kind for
// each request, and results are checked in order.
// ----------------------------------------------------------------------------
module tb_value_noise_tile_generator;
  import vntg_pkg::*;

  logic        clk;
  logic        rst;
  tile_t       tile;
  logic        push;
  logic        full;
  result_t     result;
  logic        empty;
  logic        pop;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  value_noise_tile_generator i_dut (
    .clk(clk), .rst(rst),
    .tile(tile), .push(push), .full(full),
    .result(result), .empty(empty), .pop(pop),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor copy of the register file
  logic [31:0]       seed_q;
  logic [15:0]       scale_q;
  logic signed [7:0] min_q;
  logic signed [7:0] max_q;

  result_t tile_expq[$];
  int      n_err;
  // gap percentage for both sides; zero gives a run with no idling
  int      gap_pct;

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // corner value: multiply-xor-shift hash, low 24 bits
  function automatic logic [23:0] corner_hash(logic [31:0] cx, logic [31:0] cy);
    logic [31:0] h;
    h = seed_q;
    h = h ^ (cx * HASH_MUL_X);
    h = (h << HASH_SHIFT) ^ h;
    h = h ^ (cy * HASH_MUL_Y);
    h = (h << HASH_SHIFT) ^ h;
    h = h * HASH_MUL_OUT;
    return h[23:0];
  endfunction

  // smoothstep weight in Q0.16
  function automatic logic [31:0] smooth_wt(logic [15:0] f);
    logic [63:0] f2, k;
    f2 = (64'(f) * 64'(f)) >> 16;
    k  = 64'd196608 - 64'(2) * 64'(f);
    return 32'((f2 * k) >> 16);
  endfunction

  function automatic logic [31:0] lerp_q(logic [31:0] a, logic [31:0] b, logic [31:0] w);
    logic [63:0] s;
    s = 64'(a) * (64'd65536 - 64'(w)) + 64'(b) * 64'(w);
    return 32'(s >> 16);
  endfunction

  function automatic result_t tile_predict(tile_t t);
    result_t     r;
    logic [31:0] x, y, px, py, x0, y0, wx, wy, smp;
    logic [63:0] prod;
    int          rng, h;
    x  = 32'(t.tile_x);
    y  = 32'(t.tile_y);
    px = x * 32'(scale_q);
    py = y * 32'(scale_q);
    x0 = px >> 16;
    y0 = py >> 16;
    wx = smooth_wt(px[15:0]);
    wy = smooth_wt(py[15:0]);
    smp = lerp_q(lerp_q(corner_hash(x0, y0), corner_hash(x0 + 1, y0), wx),
                 lerp_q(corner_hash(x0, y0 + 1), corner_hash(x0 + 1, y0 + 1), wx), wy);
    rng = int'(max_q) - int'(min_q) + 1;
    // empty or inverted range maps downward from min, then clamps
    if (rng > 0) begin
      prod = 64'(smp) * 64'(rng);
      h = int'(min_q) + int'(prod >> 24);
    end else begin
      prod = 64'(smp) * 64'(-rng);
      h = int'(min_q) - int'(prod >> 24);
    end
    if (h > int'(max_q)) h = int'(max_q);
    r.tile_height = h[7:0];
    if ((x + y) % 13 == 0) r.tile_kind = KIND_BLOCKED;
    else if ((3 * x + 7 * y) % 5 == 0) r.tile_kind = KIND_DIRT;
    else r.tile_kind = KIND_GRASS;
    return r;
  endfunction

  // APB write: setup then access; pready is always high
  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_SEED:  seed_q  = val;
      REG_SCALE: scale_q = val[15:0];
      REG_MIN:   min_q   = val[7:0];
      default:   max_q   = val[7:0];
    endcase
  endtask

  task automatic set_config(logic [31:0] sd, logic [15:0] sc, logic [7:0] mn, logic [7:0] mx);
    reg_write(REG_SEED, sd);
    reg_write(REG_SCALE, {16'd0, sc});
    reg_write(REG_MIN, {24'd0, mn});
    reg_write(REG_MAX, {24'd0, mx});
  endtask

  // one request, held until accepted; push stays high for a following
  // request and drops only on an idle cycle or when the sender stops
  task automatic send_tile(logic [11:0] x, logic [11:0] y);
    tile_t t;
    t.tile_x = x;
    t.tile_y = y;
    while ($urandom_range(99) < gap_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    tile <= t;
    tile_expq.push_back(tile_predict(t));
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // sender goes idle, then wait out every pending result
  task automatic drain_all();
    push <= 1'b0;
    @(posedge clk);
    while (tile_expq.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // result checker and pop driver
  always @(posedge clk) begin
    result_t exp_r;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (tile_expq.size() == 0) begin
          $display("%0t: unexpected result %h", $time, result);
          n_err++;
        end else begin
          exp_r = tile_expq.pop_front();
          if (result.tile_height !== exp_r.tile_height) begin
            $display("%0t: height expected %0d actual %0d", $time,
                     exp_r.tile_height, result.tile_height);
            n_err++;
          end
          if (result.tile_kind !== exp_r.tile_kind) begin
            $display("%0t: kind expected %0d actual %0d", $time,
                     exp_r.tile_kind, result.tile_kind);
            n_err++;
          end
        end
      end
      pop <= ($urandom_range(99) >= gap_pct);
    end
  end

  task automatic test_directed();
    gap_pct = 21;
    send_tile(12'd0, 12'd0);
    send_tile(12'hFFF, 12'hFFF);
    send_tile(12'hFFF, 12'd0);
    send_tile(12'd0, 12'hFFF);
    send_tile(12'd13, 12'd0);
    send_tile(12'd5, 12'd0);
    send_tile(12'd1, 12'd2);
    send_tile(12'hAAA, 12'h555);
    send_tile(12'h555, 12'hAAA);
    drain_all();
    // scale zero: all tiles land in cell 0 with zero weight
    set_config(32'hFFFF_FFFF, 16'd0, 8'h80, 8'h7F);
    send_tile(12'd7, 12'd9);
    send_tile(12'hFFF, 12'hFFF);
    drain_all();
    // max scale, min above max
    set_config(32'h1234_5678, 16'hFFFF, 8'h7F, 8'h80);
    send_tile(12'hFFF, 12'hFFF);
    send_tile(12'd100, 12'd3);
    drain_all();
    // min equals max, and inverted by one
    set_config(32'd0, 16'h8000, 8'd3, 8'd3);
    send_tile(12'd11, 12'd22);
    drain_all();
    set_config(32'd1, 16'd1, 8'd4, 8'd3);
    send_tile(12'hFFF, 12'd1);
    send_tile(12'd33, 12'd44);
    drain_all();
  endtask

  task automatic test_random(int count, int gp);
    gap_pct = gp;
    repeat (count) send_tile(12'($urandom), 12'($urandom));
  endtask

  task automatic test_random_configs();
    logic [7:0] a, b;
    for (int ph = 0; ph < 6; ph++) begin
      a = 8'($urandom);
      b = 8'($urandom);
      if (ph < 4 && $signed(a) > $signed(b)) {a, b} = {b, a};
      set_config($urandom, 16'($urandom), a, b);
      test_random(100, 21);
      drain_all();
    end
    // stretch with no idling on either side
    test_random(150, 0);
    drain_all();
    set_config(32'd0, 16'd7864, 8'd0, 8'd7);
    test_random(100, 21);
    // sender holds off until every expected result has come
    push <= 1'b0;
    @(posedge clk);
    while (tile_expq.size() != 0) @(posedge clk);
    test_random(50, 21);
  endtask

  initial begin
    n_err   = 0;
    gap_pct = 21;
    rst = 1'b1; push = 1'b0; tile = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    seed_q = 32'd0; scale_q = 16'd7864; min_q = 8'sd0; max_q = 8'sd7;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_configs();
    drain_all();
    if (n_err == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
